@@ sv/arpns_pkg.sv @@
// Shared constants for the arpeggiator note stepper: field widths,
// mode, direction and register codes, default sizes.
// No dependencies.
package arpns_pkg;

  // default sizes, handed to the top level parameters as their defaults
  localparam int MAX_HELD_DEF    = 16;
  localparam int MAX_OCTAVES_DEF = 8;

  // item field widths
  localparam int MODE_W  = 2;
  localparam int PITCH_W = 7;
  localparam int VEL_W   = 8;
  localparam int OUT_W   = 8;

  // configuration register widths
  localparam int DIR_W  = 2;
  localparam int RNG_W  = 4;
  localparam int CFG_W  = 4;
  localparam int CIDX_W = 1;

  // octave number width (octave is below the clamped range)
  localparam int OCT_W = 4;

  localparam int SEMITONES = 12;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_UP     = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_UPDOWN = 2'd2;
  localparam logic [DIR_W-1:0] DIR_STICKY = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_DIRECTION    = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_OCTAVE_RANGE = 1'b1;

  localparam logic [RNG_W-1:0] RNG_RESET = 4'd1;

endpackage

@@ sv/arpns_in_if.sv @@
// Input channel of the arpeggiator note stepper: valid/ready plus note item.
// Depends on arpns_pkg.
interface arpns_in_if;
  logic                             valid;
  logic                             ready;
  logic [arpns_pkg::MODE_W-1:0]     mode;
  logic [arpns_pkg::PITCH_W-1:0]    note_pitch;
  logic [arpns_pkg::VEL_W-1:0]      note_velocity;

  modport source (output valid, output mode, output note_pitch, output note_velocity,
                  input ready);
  modport sink   (input valid, input mode, input note_pitch, input note_velocity,
                  output ready);
endinterface

@@ sv/arpns_out_if.sv @@
// Output channel of the arpeggiator note stepper: valid/ready plus step item.
// Depends on arpns_pkg.
interface arpns_out_if;
  logic                          valid;
  logic                          ready;
  logic [arpns_pkg::OUT_W-1:0]   step_pitch;
  logic [arpns_pkg::VEL_W-1:0]   step_velocity;

  modport source (output valid, output step_pitch, output step_velocity, input ready);
  modport sink   (input valid, input step_pitch, input step_velocity, output ready);
endinterface

@@ sv/arpns_note_ram.sv @@
// Held-note store: one write port, one read port with registered read data.
// Depends on arpns_pkg.
module arpns_note_ram #(
  parameter int DEPTH = arpns_pkg::MAX_HELD_DEF,
  parameter int AW    = 4
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [arpns_pkg::PITCH_W-1:0] wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [arpns_pkg::PITCH_W-1:0] rdata_o
);

  logic [arpns_pkg::PITCH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/arpns_divmod.sv @@
// Iterative divide unit: one compare and subtract per cycle, gives quotient
// (octave) and remainder (note slot). Depends on arpns_pkg.
module arpns_divmod #(
  parameter int SW = 9,
  parameter int CW = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [SW-1:0]               dividend_i,
  input  logic [CW-1:0]               divisor_i,
  output logic                        done_o,
  output logic [SW-1:0]               rem_o,
  output logic [arpns_pkg::OCT_W-1:0] quo_o
);

  logic                        busy_q, busy_d;
  logic [SW-1:0]               rem_q, rem_d;
  logic [arpns_pkg::OCT_W-1:0] quo_q, quo_d;
  logic [SW-1:0]               dsr;
  logic                        fits;

  assign dsr  = SW'(divisor_i);
  assign fits = (rem_q >= dsr);

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = dividend_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsr;
        quo_d = quo_q + arpns_pkg::OCT_W'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = busy_q && !fits;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

@@ sv/arpeggiator_note_stepper_unit.sv @@
// Arpeggiator note stepper top level: sequencer, held-note store, divide unit.
// Depends on arpns_pkg, arpns_in_if, arpns_out_if, arpns_note_ram, arpns_divmod.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    mode, note_pitch, note_velocity
//   out_o    out  valid/ready    step_pitch, step_velocity
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// One item at a time. A note on or off scans the sorted store, a read and a
// compare state for each held note up to the slot, then moves the entries
// above it, a read and a write state each. A tick runs the multiply, length,
// position, divide, add and output states; the divide unit is the octave loop.
// Reset: count, step, velocity, valid to 0, DIR_UP, range 1; no clearing pass.
// A result waits in the output register while the next item is taken in.
module arpeggiator_note_stepper_unit #(
  parameter int MAX_HELD    = arpns_pkg::MAX_HELD_DEF,
  parameter int MAX_OCTAVES = arpns_pkg::MAX_OCTAVES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [arpns_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [arpns_pkg::CFG_W-1:0]   cfg_data_i,
  arpns_in_if.sink                      in_i,
  arpns_out_if.source                   out_o
);

  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int TW = $clog2(MAX_HELD * MAX_OCTAVES + 1);
  localparam int SW = $clog2(2 * MAX_HELD * MAX_OCTAVES + 1);
  localparam int PW = arpns_pkg::PITCH_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_INS_RD, S_INS_WR, S_DEL_RD,
    S_DEL_WR, S_TICK_MUL, S_TICK_LEN, S_TICK_POS, S_DIV, S_ADD, S_OUT
  } state_e;

  state_e                          state_q, state_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic [SW-1:0]                   step_q, step_d;
  logic [arpns_pkg::VEL_W-1:0]     vel_q, vel_d;
  logic [arpns_pkg::DIR_W-1:0]     dir_q, dir_d;
  logic [arpns_pkg::RNG_W-1:0]     rng_q, rng_d;
  logic [PW-1:0]                   pitch_q, pitch_d;
  logic [arpns_pkg::VEL_W-1:0]     vin_q, vin_d;
  logic                            on_q, on_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   j_q, j_d;
  logic                            present_q, present_d;
  logic [TW-1:0]                   total_q, total_d;
  logic [SW-1:0]                   len_q, len_d;
  logic [SW-1:0]                   stepc_q, stepc_d;
  logic [arpns_pkg::OUT_W-1:0]     res_q, res_d;
  logic                            oval_q, oval_d;
  logic [arpns_pkg::OUT_W-1:0]     opitch_q, opitch_d;
  logic [arpns_pkg::VEL_W-1:0]     ovel_q, ovel_d;

  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic [PW-1:0]                   mem_wdata, mem_rdata;

  logic                            div_start, div_done;
  logic [SW-1:0]                   div_s, div_rem;
  logic [arpns_pkg::OCT_W-1:0]     div_quo;

  logic                            in_acc;
  logic [arpns_pkg::RNG_W-1:0]     rng_eff;
  logic [SW-1:0]                   tot_s, two_t, stepc_inc;
  logic [CW:0]                     j_inc;
  logic [PW+1:0]                   psum;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign rng_eff = (rng_q == '0) ? arpns_pkg::RNG_W'(1) :
                   (rng_q > arpns_pkg::RNG_W'(MAX_OCTAVES)) ?
                   arpns_pkg::RNG_W'(MAX_OCTAVES) : rng_q;

  assign tot_s     = SW'(total_q);
  assign two_t     = tot_s << 1;
  assign stepc_inc = stepc_q + SW'(1);
  assign j_inc     = (CW+1)'(j_q) + (CW+1)'(1);
  assign psum      = (PW+2)'(mem_rdata) + (PW+2)'(div_quo) * (PW+2)'(arpns_pkg::SEMITONES);

  // slot position inside the pattern for the current direction
  always_comb begin
    case (dir_q)
      arpns_pkg::DIR_DOWN:   div_s = tot_s - SW'(1) - stepc_q;
      arpns_pkg::DIR_UPDOWN: div_s = (stepc_q < tot_s) ? stepc_q : two_t - SW'(2) - stepc_q;
      arpns_pkg::DIR_STICKY: div_s = (stepc_q < tot_s) ? stepc_q : two_t - SW'(1) - stepc_q;
      default:               div_s = stepc_q;
    endcase
  end

  // store port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = j_q[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx_q[AW-1:0];
    case (state_q)
      S_INS_RD: begin
        mem_raddr = AW'(j_q - CW'(1));
        if (j_q == idx_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q[AW-1:0];
          mem_wdata = pitch_q;
        end
      end
      S_INS_WR: mem_we = 1'b1;
      S_DEL_RD: mem_raddr = AW'(j_inc);
      S_DEL_WR: mem_we = 1'b1;
      S_DIV:    mem_raddr = div_rem[AW-1:0];
      default:  mem_raddr = idx_q[AW-1:0];
    endcase
  end

  assign div_start = (state_q == S_TICK_POS);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    vel_d     = vel_q;
    dir_d     = dir_q;
    rng_d     = rng_q;
    pitch_d   = pitch_q;
    vin_d     = vin_q;
    on_d      = on_q;
    idx_d     = idx_q;
    j_d       = j_q;
    present_d = present_q;
    total_d   = total_q;
    len_d     = len_q;
    stepc_d   = stepc_q;
    res_d     = res_q;
    oval_d    = oval_q;
    opitch_d  = opitch_q;
    ovel_d    = ovel_q;

    if (oval_q && out_o.ready) begin
      oval_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        arpns_pkg::CFG_DIRECTION:    dir_d = cfg_data_i[arpns_pkg::DIR_W-1:0];
        arpns_pkg::CFG_OCTAVE_RANGE: rng_d = cfg_data_i[arpns_pkg::RNG_W-1:0];
        default:                     dir_d = dir_q;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pitch_d = in_i.note_pitch;
          vin_d   = in_i.note_velocity;
          on_d    = (in_i.mode == arpns_pkg::MODE_NOTE_ON);
          idx_d   = '0;
          case (in_i.mode)
            arpns_pkg::MODE_NOTE_ON,
            arpns_pkg::MODE_NOTE_OFF: state_d = S_SCAN_RD;
            arpns_pkg::MODE_TICK: begin
              if (cnt_q != '0) state_d = S_TICK_MUL;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx_q == cnt_q) begin
          present_d = 1'b0;
          state_d   = S_DECIDE;
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (mem_rdata < pitch_q) begin
          idx_d   = idx_q + CW'(1);
          state_d = S_SCAN_RD;
        end else begin
          present_d = (mem_rdata == pitch_q);
          state_d   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        if (on_q) begin
          if (present_q) begin
            vel_d = vin_q;
          end else if (cnt_q != CW'(MAX_HELD)) begin
            j_d     = cnt_q;
            state_d = S_INS_RD;
          end
        end else if (present_q) begin
          j_d     = idx_q;
          state_d = S_DEL_RD;
        end else if (cnt_q == '0) begin
          step_d = '0;
        end
      end
      S_INS_RD: begin
        if (j_q == idx_q) begin
          // slot is open: drop the note in
          cnt_d   = cnt_q + CW'(1);
          vel_d   = vin_q;
          if (cnt_q == '0) step_d = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        j_d     = j_q - CW'(1);
        state_d = S_INS_RD;
      end
      S_DEL_RD: begin
        if (j_inc >= (CW+1)'(cnt_q)) begin
          cnt_d   = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) step_d = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        j_d     = CW'(j_inc);
        state_d = S_DEL_RD;
      end
      S_TICK_MUL: begin
        total_d = TW'(TW'(cnt_q) * TW'(rng_eff));
        state_d = S_TICK_LEN;
      end
      S_TICK_LEN: begin
        case (dir_q)
          arpns_pkg::DIR_UPDOWN: len_d = (total_q > TW'(1)) ? two_t - SW'(2) : SW'(1);
          arpns_pkg::DIR_STICKY: len_d = (total_q > TW'(1)) ? two_t : SW'(1);
          default:               len_d = tot_s;
        endcase
        // a stale step past the pattern end restarts it
        stepc_d = (step_q >= len_d) ? '0 : step_q;
        state_d = S_TICK_POS;
      end
      S_TICK_POS: begin
        step_d  = (stepc_inc >= len_q) ? '0 : stepc_inc;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_d = S_ADD;
      end
      S_ADD: begin
        res_d   = psum[PW+1] ? '1 : psum[arpns_pkg::OUT_W-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!oval_q || out_o.ready) begin
          oval_d   = 1'b1;
          opitch_d = res_q;
          ovel_d   = vel_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      vel_q   <= '0;
      dir_q   <= arpns_pkg::DIR_UP;
      rng_q   <= arpns_pkg::RNG_RESET;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      vel_q   <= vel_d;
      dir_q   <= dir_d;
      rng_q   <= rng_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q   <= pitch_d;
    vin_q     <= vin_d;
    on_q      <= on_d;
    idx_q     <= idx_d;
    j_q       <= j_d;
    present_q <= present_d;
    total_q   <= total_d;
    len_q     <= len_d;
    stepc_q   <= stepc_d;
    res_q     <= res_d;
    opitch_q  <= opitch_d;
    ovel_q    <= ovel_d;
  end

  assign out_o.valid         = oval_q;
  assign out_o.step_pitch    = opitch_q;
  assign out_o.step_velocity = ovel_q;

  arpns_note_ram #(
    .DEPTH (MAX_HELD),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  arpns_divmod #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_s),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .quo_o      (div_quo)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_HELD))
    else $error("held note count above capacity");

  a_div_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divide unit finished outside a tick");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(oval_q) |-> $past(state_q) == S_OUT)
    else $error("result raised without a finished tick");

endmodule
